// ===== hw/rtl/rlim_pkg.sv =====
// Package for the per-source fixed-window rate limiter.
// Holds shared constants, verdict codes and the item, table-entry and status types.
// No dependencies.
`default_nettype none

package rlim_pkg;

    localparam int TABLE_ENTRIES_DEF = 1024;

    localparam logic [31:0] THRESHOLD_RST = 32'd10;
    localparam logic [63:0] WINDOW_RST    = 64'd1000000000;

    localparam logic [13:0] IPV4_MIN_BYTES = 14'd34;
    localparam logic [15:0] ETYPE_IPV4     = 16'h0800;

    localparam logic [1:0] VERDICT_PASS  = 2'd0;
    localparam logic [1:0] VERDICT_DROP  = 2'd1;
    localparam logic [1:0] VERDICT_ABORT = 2'd2;
    localparam logic [1:0] VERDICT_RSVD  = 2'd3;

    localparam logic CFG_THRESHOLD = 1'b0;
    localparam logic CFG_WINDOW    = 1'b1;

    localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;

    // One classified packet on its way from the front to the back
    typedef struct packed {
        logic        eligible;
        logic [31:0] key;
        logic [63:0] now;
    } item_t;

    // One table slot as held in the RAM
    typedef struct packed {
        logic [31:0] key;
        logic [63:0] start;
        logic [31:0] count;
    } entry_t;

    // Status from the back end
    typedef struct packed {
        logic full;
        logic idle;
    } stat_t;

endpackage

`default_nettype wire

// ===== hw/rtl/rlim_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module rlim_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== hw/rtl/rlim_front.sv =====
// Front end: classify incoming packets and hold them in a two-deep queue.
// Depends on rlim_pkg.
`default_nettype none

module rlim_front
    import rlim_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [13:0] frame_length,
    input  wire logic [15:0] ether_type,
    input  wire logic [31:0] source_address,
    input  wire logic [63:0] now_ns,
    output logic             avail,
    output item_t            head,
    input  wire logic        pop
);

    item_t       q_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  level_reg, level_next;
    logic        push;
    item_t       item_in;

    assign busy  = (level_reg == 2'd2);
    assign avail = (level_reg != 2'd0);
    assign head  = q_reg[rd_ptr_reg];
    assign push  = start && !busy;

    always_comb
    begin
        item_in.eligible = (frame_length >= IPV4_MIN_BYTES) && (ether_type == ETYPE_IPV4);
        item_in.key      = source_address;
        item_in.now      = now_ns;
    end

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop  ? ~rd_ptr_reg : rd_ptr_reg;
        level_next  = level_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            level_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= item_in;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/rlim_back.sv =====
// Back end: scan the source table, update the matching slot or insert a new one,
// and issue the verdict. Depends on rlim_pkg and rlim_ram.
`default_nettype none

module rlim_back
    import rlim_pkg::*;
#(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        avail,
    input  wire item_t       head,
    output logic             pop,
    input  wire logic [31:0] threshold,
    input  wire logic [63:0] window_ns,
    output logic             done,
    output logic [1:0]       verdict,
    output stat_t            stat
);

    localparam int IW = $clog2(TABLE_ENTRIES);
    localparam int OW = $clog2(TABLE_ENTRIES + 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_ISSUE = 3'd1;
    localparam logic [2:0] S_CHECK = 3'd2;
    localparam logic [2:0] S_UPD   = 3'd3;
    localparam logic [2:0] S_INS   = 3'd4;

    logic [2:0]    state_reg, state_next;
    logic [IW-1:0] idx_reg, idx_next;
    logic [OW-1:0] occ_reg, occ_next;
    logic          done_reg, done_next;
    logic [1:0]    verdict_reg, verdict_next;
    logic [31:0]   key_reg, key_next;
    logic [63:0]   now_reg, now_next;
    entry_t        ent_reg, ent_next;
    logic [63:0]   elapsed_reg, elapsed_next;

    logic          we;
    logic [IW-1:0] waddr;
    entry_t        wdata;
    entry_t        rdata;
    logic [31:0]   cnt_inc;
    logic          full;

    rlim_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (TABLE_ENTRIES)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (idx_reg),
        .rdata (rdata)
    );

    assign full      = (occ_reg == OW'(TABLE_ENTRIES));
    assign cnt_inc   = (ent_reg.count == COUNT_MAX) ? ent_reg.count : ent_reg.count + 32'd1;
    assign done      = done_reg;
    assign verdict   = verdict_reg;
    assign stat.full = full;
    assign stat.idle = (state_reg == S_IDLE);

    always_comb
    begin
        state_next   = state_reg;
        idx_next     = idx_reg;
        occ_next     = occ_reg;
        done_next    = 1'b0;
        verdict_next = verdict_reg;
        key_next     = key_reg;
        now_next     = now_reg;
        ent_next     = ent_reg;
        elapsed_next = elapsed_reg;
        pop          = 1'b0;
        we           = 1'b0;
        waddr        = idx_reg;
        wdata        = ent_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (avail)
                begin
                    pop      = 1'b1;
                    key_next = head.key;
                    now_next = head.now;
                    idx_next = '0;
                    if (!head.eligible)
                    begin
                        done_next    = 1'b1;
                        verdict_next = VERDICT_PASS;
                    end
                    else if (occ_reg == '0)
                    begin
                        state_next = S_INS;
                    end
                    else
                    begin
                        state_next = S_ISSUE;
                    end
                end
            end
            S_ISSUE:
            begin
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (rdata.key == key_reg)
                begin
                    ent_next     = rdata;
                    elapsed_next = now_reg - rdata.start;
                    state_next   = S_UPD;
                end
                else if (OW'(idx_reg) + OW'(1) == occ_reg)
                begin
                    state_next = S_INS;
                end
                else
                begin
                    idx_next   = idx_reg + IW'(1);
                    state_next = S_ISSUE;
                end
            end
            S_UPD:
            begin
                we        = 1'b1;
                wdata.key = key_reg;
                done_next = 1'b1;
                if (elapsed_reg < window_ns)
                begin
                    wdata.start  = ent_reg.start;
                    wdata.count  = cnt_inc;
                    verdict_next = (cnt_inc > threshold) ? VERDICT_DROP : VERDICT_PASS;
                end
                else
                begin
                    wdata.start  = now_reg;
                    wdata.count  = 32'd1;
                    verdict_next = VERDICT_PASS;
                end
                state_next = S_IDLE;
            end
            S_INS:
            begin
                done_next  = 1'b1;
                state_next = S_IDLE;
                if (full)
                begin
                    verdict_next = VERDICT_ABORT;
                end
                else
                begin
                    we           = 1'b1;
                    waddr        = occ_reg[IW-1:0];
                    wdata.key    = key_reg;
                    wdata.start  = now_reg;
                    wdata.count  = 32'd1;
                    occ_next     = occ_reg + OW'(1);
                    verdict_next = VERDICT_PASS;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            occ_reg     <= '0;
            done_reg    <= 1'b0;
            verdict_reg <= VERDICT_PASS;
        end
        else
        begin
            state_reg   <= state_next;
            occ_reg     <= occ_next;
            done_reg    <= done_next;
            verdict_reg <= verdict_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg     <= idx_next;
        key_reg     <= key_next;
        now_reg     <= now_next;
        ent_reg     <= ent_next;
        elapsed_reg <= elapsed_next;
    end

endmodule

`default_nettype wire

// ===== hw/rtl/per_source_fixed_window_rate_limiter.sv =====
// Top level of the per-source fixed-window rate limiter.
// Depends on rlim_pkg, rlim_front, rlim_back and rlim_ram.
//
// Usage:
//   Present a packet transaction on frame_length, ether_type, source_address
//   and now_ns with start high; it is taken at a clock edge where busy is low.
//   The front classifies the packet and parks it in a two-deep queue, so
//   busy rises only when two transactions wait for the back end.
//   Each transaction yields one verdict (pass, drop, abort) on verdict with
//   done high for a single cycle; the receiver must take it then.
//   Verdicts come out in the order packets were taken.
// Scan:
//   A short or non-IPv4 packet is passed as soon as the back end pops it,
//   with no table scan. An IPv4 packet scans the source table linearly,
//   slot by slot (RAM read, then key compare): a hit updates that slot, a
//   miss inserts a new slot, or aborts when all are taken. The single RAM
//   read port sets the scan pace; the back end takes one packet at a time.
// Reset:
//   rst_n clears the queue, the fill count (so the table reads empty) and
//   restores threshold to 10 and window_ns to 1e9 ns. No clearing pass.
// Configuration:
//   cfg_we writes cfg_data into register cfg_index (0 threshold, 1 window_ns);
//   write only while no transaction is in flight.
`default_nettype none

module per_source_fixed_window_rate_limiter
    import rlim_pkg::*;
#(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [13:0] frame_length,
    input  wire logic [15:0] ether_type,
    input  wire logic [31:0] source_address,
    input  wire logic [63:0] now_ns,
    output logic             done,
    output logic [1:0]       verdict,
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [63:0] cfg_data
);

    logic [31:0] threshold_reg;
    logic [63:0] window_reg;
    logic        avail;
    item_t       head;
    logic        pop;
    stat_t       stat;

    // Hold the configuration registers; update on a write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= THRESHOLD_RST;
            window_reg    <= WINDOW_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_THRESHOLD: threshold_reg <= cfg_data[31:0];
                CFG_WINDOW:    window_reg    <= cfg_data;
                default:       ;
            endcase
        end
    end

    rlim_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .frame_length   (frame_length),
        .ether_type     (ether_type),
        .source_address (source_address),
        .now_ns         (now_ns),
        .avail          (avail),
        .head           (head),
        .pop            (pop)
    );

    rlim_back #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .avail     (avail),
        .head      (head),
        .pop       (pop),
        .threshold (threshold_reg),
        .window_ns (window_reg),
        .done      (done),
        .verdict   (verdict),
        .stat      (stat)
    );

    // Never issue the reserved verdict code
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (verdict != VERDICT_RSVD))
        else $error("reserved verdict issued");

    // Abort only when every slot is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && verdict == VERDICT_ABORT) |-> stat.full)
        else $error("abort with free slots");

    // Slots are never freed
    assert property (@(posedge clk) disable iff (!rst_n)
        stat.full |=> stat.full)
        else $error("table lost an entry");

    // Queue full means the back end is busy with a transaction or has only just finished one
    assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> !stat.idle || $past(!stat.idle))
        else $error("queue stuck while back end idle");

endmodule

`default_nettype wire
